FILE: rtl/dqcr_pkg.sv
`default_nettype none

package dqcr_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int PPR_WIDTH   = 16;
   localparam int RATE_WIDTH  = 32;
   localparam int OUT_WIDTH   = 32;

   // numerator is |count delta| * 10, which needs three more bits
   localparam int NUM_WIDTH   = COUNT_WIDTH + 3;
   localparam int STEP_WIDTH  = $clog2(NUM_WIDTH);
   localparam int SAT_WIDTH   = (NUM_WIDTH > 33) ? NUM_WIDTH : 33;

   localparam logic [PPR_WIDTH-1:0] PPR_RESET = PPR_WIDTH'(1400);

   localparam logic [SAT_WIDTH-1:0] POS_LIMIT = SAT_WIDTH'(64'h7FFF_FFFF);
   localparam logic [SAT_WIDTH-1:0] NEG_LIMIT = SAT_WIDTH'(64'h8000_0000);

   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_RATE   = 2'd2
   } mode_type;

   typedef enum logic {
      REG_PPR_ONE = 1'b0,
      REG_PPR_TWO = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_DIVIDE  = 2'd1,
      ST_PUBLISH = 2'd2
   } state_type;

   typedef struct packed {
      logic sample;
      logic clear;
      logic rate;
   } lane_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [OUT_WIDTH-1:0] count;
      logic [RATE_WIDTH-1:0] speed;
   } lane_sts_type;

endpackage

`default_nettype wire

FILE: rtl/dqcr_div.sv
`default_nettype none

module dqcr_div
   import dqcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NUM_WIDTH-1:0] numer,
   input  wire logic [PPR_WIDTH-1:0] denom,
   output logic                      done,
   output logic [NUM_WIDTH-1:0]      quot
);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [NUM_WIDTH-1:0]  num_ff, num_in;
   logic [PPR_WIDTH-1:0]  rem_ff, rem_in;
   logic [PPR_WIDTH-1:0]  den_ff, den_in;

   logic [PPR_WIDTH:0]    trial;
   logic [PPR_WIDTH:0]    diff;
   logic                  ge;

   // restoring division, one quotient bit per cycle shifted into the numerator
   assign trial = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_WIDTH'(NUM_WIDTH - 1);
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (run_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], ge};
         rem_in = ge ? diff[PPR_WIDTH-1:0] : trial[PPR_WIDTH-1:0];
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

FILE: rtl/dqcr_lane.sv
`default_nettype none

module dqcr_lane
   import dqcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lane_cmd_type         cmd,
   input  wire logic                 enc_a,
   input  wire logic                 enc_b,
   input  wire logic [PPR_WIDTH-1:0] ppr,
   output lane_sts_type              sts
);

   logic                    prev_a_ff, prev_a_in;
   logic [COUNT_WIDTH-1:0]  edges_ff, edges_in;
   logic [COUNT_WIDTH-1:0]  snap_ff, snap_in;
   logic [RATE_WIDTH-1:0]   speed_ff, speed_in;
   logic                    neg_ff, neg_in;

   logic [COUNT_WIDTH-1:0]  delta;
   logic [COUNT_WIDTH-1:0]  mag;
   logic [NUM_WIDTH-1:0]    numer;
   logic [PPR_WIDTH-1:0]    divisor;
   logic                    div_done;
   logic [NUM_WIDTH-1:0]    quot;
   logic [SAT_WIDTH-1:0]    quot_ext;

   assign delta   = edges_ff - snap_ff;
   assign mag     = delta[COUNT_WIDTH-1] ? (~delta + 1'b1) : delta;
   assign numer   = (NUM_WIDTH'(mag) << 3) + (NUM_WIDTH'(mag) << 1);
   assign divisor = (ppr == '0) ? PPR_WIDTH'(1) : ppr;
   assign quot_ext = SAT_WIDTH'(quot);

   dqcr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.rate),
      .numer (numer),
      .denom (divisor),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      prev_a_in = prev_a_ff;
      edges_in  = edges_ff;
      snap_in   = snap_ff;
      speed_in  = speed_ff;
      neg_in    = neg_ff;
      if (cmd.sample) begin
         if (enc_a != prev_a_ff) begin
            prev_a_in = enc_a;
            // x2 decode: count up when a and b agree after the edge
            edges_in  = (enc_a == enc_b) ? edges_ff + 1'b1 : edges_ff - 1'b1;
         end
      end else if (cmd.clear) begin
         edges_in = '0;
      end else if (cmd.rate) begin
         snap_in = edges_ff;
         neg_in  = delta[COUNT_WIDTH-1];
      end
      if (div_done) begin
         if (!neg_ff) begin
            speed_in = (quot_ext > POS_LIMIT) ? RATE_WIDTH'(POS_LIMIT)
                                              : quot_ext[RATE_WIDTH-1:0];
         end else if (quot_ext > NEG_LIMIT) begin
            speed_in = RATE_WIDTH'(NEG_LIMIT);
         end else begin
            speed_in = ~quot_ext[RATE_WIDTH-1:0] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b0;
         edges_ff  <= '0;
         snap_ff   <= '0;
         speed_ff  <= '0;
      end else begin
         prev_a_ff <= prev_a_in;
         edges_ff  <= edges_in;
         snap_ff   <= snap_in;
         speed_ff  <= speed_in;
      end
      neg_ff <= neg_in;
   end

   assign sts.done  = div_done;
   assign sts.count = OUT_WIDTH'(edges_in);
   assign sts.speed = speed_ff;

endmodule

`default_nettype wire

FILE: rtl/dual_quadrature_counter_rate.sv
`default_nettype none

// channel   direction  handshake            payload
// req       in         req_valid/req_stall  mode, a and b levels of both encoders
// rsp       out        rsp_valid/rsp_stall  both counts, both rates
// csr       in         apb write/read       pulses per revolution, one and two
//
// pin sample, clear and unused-mode beats are answered from idle, back to back while the output is free.
// a rate beat runs the two lane dividers, which produce one quotient bit
// a cycle over 35 bits; the lanes then store the rate, which is published once the output is free.
// reset is synchronous: counts, snapshots and rates clear, divisors go to 1400.
// a stalled result sits in the output register and holds req_stall high until taken.

module dual_quadrature_counter_rate
   import dqcr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_mode,
   input  wire logic                      req_enc_one_a,
   input  wire logic                      req_enc_one_b,
   input  wire logic                      req_enc_two_a,
   input  wire logic                      req_enc_two_b,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [OUT_WIDTH-1:0]    rsp_count_one,
   output logic signed [OUT_WIDTH-1:0]    rsp_count_two,
   output logic signed [RATE_WIDTH-1:0]   rsp_rate_one,
   output logic signed [RATE_WIDTH-1:0]   rsp_rate_two,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]   count_one_ff, count_two_ff;
   logic [RATE_WIDTH-1:0]  rate_one_ff, rate_two_ff;
   logic [PPR_WIDTH-1:0]   ppr_one_ff, ppr_two_ff;

   logic                   out_free;
   logic                   accept;
   logic                   load_out;
   logic                   csr_write;
   reg_index_type          csr_index;
   lane_cmd_type           cmd;
   lane_sts_type           sts_one, sts_two;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd = '0;
      if (accept) begin
         case (req_mode)
            MODE_SAMPLE: cmd.sample = 1'b1;
            MODE_CLEAR:  cmd.clear  = 1'b1;
            MODE_RATE:   cmd.rate   = 1'b1;
            default:     cmd        = '0;
         endcase
      end
   end

   dqcr_lane u_lane_one (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .enc_a (req_enc_one_a),
      .enc_b (req_enc_one_b),
      .ppr   (ppr_one_ff),
      .sts   (sts_one)
   );

   dqcr_lane u_lane_two (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .enc_a (req_enc_two_a),
      .enc_b (req_enc_two_b),
      .ppr   (ppr_two_ff),
      .sts   (sts_two)
   );

   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.rate) begin
               state_in = ST_DIVIDE;
            end else if (accept) begin
               load_out = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (sts_one.done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         count_one_ff <= sts_one.count;
         count_two_ff <= sts_two.count;
         rate_one_ff  <= sts_one.speed;
         rate_two_ff  <= sts_two.speed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count_one = count_one_ff;
   assign rsp_count_two = count_two_ff;
   assign rsp_rate_one  = rate_one_ff;
   assign rsp_rate_two  = rate_two_ff;

   // registers sit on 4-byte boundaries, low address bits ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_one_ff <= PPR_RESET;
         ppr_two_ff <= PPR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PPR_ONE: ppr_one_ff <= csr_pwdata[PPR_WIDTH-1:0];
            REG_PPR_TWO: ppr_two_ff <= csr_pwdata[PPR_WIDTH-1:0];
            default:     ppr_one_ff <= ppr_one_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PPR_ONE: csr_prdata = 32'(ppr_one_ff);
         REG_PPR_TWO: csr_prdata = 32'(ppr_two_ff);
         default:     csr_prdata = '0;
      endcase
   end

   a_rate_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.rate |=> (state_ff == ST_DIVIDE))
      else $error("rate beat did not start the dividers");

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      sts_one.done == sts_two.done)
      else $error("lane dividers finished in different cycles");

   a_counts_hold_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |=> ($stable(sts_one.count) && $stable(sts_two.count)))
      else $error("count moved while a rate was being worked out");

   a_publish_only_after_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUBLISH) |-> ($past(state_ff) == ST_DIVIDE
                                    || $past(state_ff) == ST_PUBLISH))
      else $error("publish reached without a divide");

endmodule

`default_nettype wire
